/* sv/bbm_pkg.sv */
// ----------------------------------------------------------------------------
// bbm_pkg
// Shared types and constants of the box blur mean filter.
// ----------------------------------------------------------------------------
package bbm_pkg;

   localparam int MAX_WIDTH_DEF  = 1024;
   localparam int MAX_RADIUS_DEF = 4;
   localparam int PIXEL_BITS_DEF = 8;

   localparam int HEIGHT_BITS = 13;
   localparam int WIDTH_BITS  = 11;
   localparam int RADIUS_BITS = 3;
   localparam int FIELD_BITS  = 8;
   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET = HEIGHT_BITS'(480);
   localparam logic [WIDTH_BITS-1:0]  WIDTH_RESET  = WIDTH_BITS'(640);
   localparam logic [RADIUS_BITS-1:0] RADIUS_RESET = RADIUS_BITS'(1);

   // register index, paddr[3:2]
   localparam logic [1:0] REG_HEIGHT = 2'd0;
   localparam logic [1:0] REG_WIDTH  = 2'd1;
   localparam logic [1:0] REG_RADIUS = 2'd2;

   typedef struct packed {
      logic [HEIGHT_BITS-1:0] image_height;
      logic [WIDTH_BITS-1:0]  image_width;
      logic [RADIUS_BITS-1:0] window_radius;
      logic                   restart;
   } bbm_cfg_type;

   typedef struct packed {
      logic accept;
      logic update;
      logic div_start;
      logic div_step;
      logic load_out;
   } bbm_cmd_type;

   typedef struct packed {
      logic emit;
      logic div_done;
      logic out_free;
   } bbm_status_type;

endpackage

/* sv/bbm_req_if.sv */
// ----------------------------------------------------------------------------
// bbm_req_if
// Pixel input channel: valid/ready with one pixel per transaction.
// ----------------------------------------------------------------------------
interface bbm_req_if;
   logic                             valid;
   logic                             ready;
   logic [bbm_pkg::FIELD_BITS-1:0]   pixel_in;

   modport source (output valid, output pixel_in, input ready);
   modport sink   (input valid, input pixel_in, output ready);
endinterface

/* sv/bbm_rsp_if.sv */
// ----------------------------------------------------------------------------
// bbm_rsp_if
// Mean output channel: valid/ready with one filtered pixel per transaction.
// ----------------------------------------------------------------------------
interface bbm_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [bbm_pkg::FIELD_BITS-1:0]   mean_out;
   logic                             frame_last;

   modport source (output valid, output mean_out, output frame_last, input ready);
   modport sink   (input valid, input mean_out, input frame_last, output ready);
endinterface

/* sv/bbm_csr.sv */
// ----------------------------------------------------------------------------
// bbm_csr
// APB-style register file: image height, image width, window radius.
// ----------------------------------------------------------------------------
module bbm_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [bbm_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [bbm_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [bbm_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                               csr_pready,
   output bbm_pkg::bbm_cfg_type               cfg
);
   logic [bbm_pkg::HEIGHT_BITS-1:0] height_ff, height_in;
   logic [bbm_pkg::WIDTH_BITS-1:0]  width_ff, width_in;
   logic [bbm_pkg::RADIUS_BITS-1:0] radius_ff, radius_in;
   logic                            wr_en;
   logic                            cfg_restart;
   logic [1:0]                      idx;

   assign csr_pready = 1'b1;
   assign idx   = csr_paddr[3:2];
   assign wr_en = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      height_in = height_ff;
      width_in  = width_ff;
      radius_in = radius_ff;
      cfg_restart = 1'b0;
      if (wr_en) begin
         case (idx)
            bbm_pkg::REG_HEIGHT: begin
               height_in = csr_pwdata[bbm_pkg::HEIGHT_BITS-1:0];
               cfg_restart = 1'b1;
            end
            bbm_pkg::REG_WIDTH: begin
               width_in = csr_pwdata[bbm_pkg::WIDTH_BITS-1:0];
               cfg_restart = 1'b1;
            end
            bbm_pkg::REG_RADIUS: begin
               radius_in = csr_pwdata[bbm_pkg::RADIUS_BITS-1:0];
               cfg_restart = 1'b1;
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      case (idx)
         bbm_pkg::REG_HEIGHT: csr_prdata = bbm_pkg::CSR_DATA_BITS'(height_ff);
         bbm_pkg::REG_WIDTH:  csr_prdata = bbm_pkg::CSR_DATA_BITS'(width_ff);
         bbm_pkg::REG_RADIUS: csr_prdata = bbm_pkg::CSR_DATA_BITS'(radius_ff);
         default:             csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         height_ff <= bbm_pkg::HEIGHT_RESET;
         width_ff  <= bbm_pkg::WIDTH_RESET;
         radius_ff <= bbm_pkg::RADIUS_RESET;
      end else begin
         height_ff <= height_in;
         width_ff  <= width_in;
         radius_ff <= radius_in;
      end
   end

   assign cfg.image_height  = height_ff;
   assign cfg.image_width   = width_ff;
   assign cfg.window_radius = radius_ff;
   assign cfg.restart       = cfg_restart;
endmodule

/* sv/bbm_ctrl.sv */
// ----------------------------------------------------------------------------
// bbm_ctrl
// Per-pixel sequencer: accept, update sums, and for an output pixel divide and hand off result.
// ----------------------------------------------------------------------------
module bbm_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  bbm_pkg::bbm_status_type status,
   output bbm_pkg::bbm_cmd_type    cmd
);
   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_UPDATE = 2'd1;
   localparam logic [1:0] S_DIV    = 2'd2;
   localparam logic [1:0] S_OUT    = 2'd3;

   logic [1:0] state_ff, state_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in = S_UPDATE;
            end
         end
         S_UPDATE: begin
            cmd.update = 1'b1;
            if (status.emit) begin
               cmd.div_start = 1'b1;
               state_in = S_DIV;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_DIV: begin
            if (status.div_done) begin
               state_in = S_OUT;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         S_OUT: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule

/* sv/bbm_datapath.sv */
// ----------------------------------------------------------------------------
// bbm_datapath
// Line store, column sums, running window sum, divider and output register.
// ----------------------------------------------------------------------------
module bbm_datapath #(
   parameter int MAX_WIDTH  = bbm_pkg::MAX_WIDTH_DEF,
   parameter int MAX_RADIUS = bbm_pkg::MAX_RADIUS_DEF,
   parameter int PIXEL_BITS = bbm_pkg::PIXEL_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  bbm_pkg::bbm_cfg_type            cfg,
   input  bbm_pkg::bbm_cmd_type            cmd,
   output bbm_pkg::bbm_status_type         status,
   input  logic [bbm_pkg::FIELD_BITS-1:0]  pixel_in,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [bbm_pkg::FIELD_BITS-1:0]  mean_out,
   output logic                            frame_last
);
   localparam int PB    = PIXEL_BITS;
   localparam int CW    = $clog2(MAX_WIDTH);
   localparam int WW    = $clog2(MAX_WIDTH + 1);
   localparam int RW    = $clog2(MAX_RADIUS + 1);
   localparam int SW    = RW + 1;
   localparam int RMW   = (2 * MAX_RADIUS > 1) ? $clog2(2 * MAX_RADIUS) : 1;
   localparam int HD    = 2 * MAX_RADIUS + 1;
   localparam int HIW   = $clog2(HD);
   localparam int AREA  = HD * HD;
   localparam int CSW   = PB + $clog2(2 * MAX_RADIUS + 1);
   localparam int FW    = PB + $clog2(HD + 1);
   localparam int SUMW  = PB + $clog2(AREA + 1);
   localparam int DW    = $clog2(AREA + 1);
   localparam int CTW   = $clog2(SUMW + 1);
   localparam int HB    = bbm_pkg::HEIGHT_BITS;
   localparam int RS_DEPTH = 2 * MAX_RADIUS * (2 ** CW);

   // effective configuration
   logic [HB-1:0] h_eff;
   logic [WW-1:0] w_eff;
   logic [RW-1:0] r_eff;
   logic [SW-1:0] span, side;

   assign h_eff = (cfg.image_height == '0) ? HB'(1) : cfg.image_height;
   assign r_eff = (32'(cfg.window_radius) > MAX_RADIUS) ? RW'(MAX_RADIUS)
                                                         : RW'(cfg.window_radius);
   always_comb begin
      if (cfg.image_width == '0)
         w_eff = WW'(1);
      else if (32'(cfg.image_width) > MAX_WIDTH)
         w_eff = WW'(MAX_WIDTH);
      else
         w_eff = WW'(cfg.image_width);
   end
   assign span = {r_eff, 1'b0};
   assign side = {r_eff, 1'b1};

   // counters and sums
   logic [HB-1:0]   row_ff, row_in;
   logic [CW-1:0]   col_ff, col_in;
   logic [RMW-1:0]  rmod_ff, rmod_in;
   logic [HIW-1:0]  hmod_ff, hmod_in;
   logic [SUMW-1:0] ws_ff, ws_in;
   logic [PB-1:0]   pix_ff;
   logic [FW-1:0]   hist_ff [HD];

   // memories
   logic [CSW-1:0]  cs_mem [MAX_WIDTH];
   logic [PB-1:0]   rs_mem [RS_DEPTH];
   logic [CSW-1:0]  cs_rd_ff;
   logic [PB-1:0]   rs_rd_ff;
   logic [RMW+CW-1:0] rs_addr;

   assign rs_addr = {rmod_ff, col_ff};

   logic [15:0] pix_wide;
   assign pix_wide = 16'(pixel_in);

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         pix_ff   <= pix_wide[PB-1:0];
         cs_rd_ff <= cs_mem[col_ff];
         rs_rd_ff <= rs_mem[rs_addr];
      end
   end

   // update arithmetic
   logic [CSW-1:0] cs_cur, old_row, cs_new;
   logic [FW-1:0]  full, hist_old;
   logic [SUMW-1:0] ws_base, ws_upd;
   logic row_ge, col_ge, emit, last, col_wrap, row_wrap;
   logic [WW:0]   col_next;
   logic [HB:0]   row_next;

   assign cs_cur  = (row_ff == '0 || span == '0) ? '0 : cs_rd_ff;
   assign old_row = (32'(row_ff) >= 32'(span)) ? CSW'(rs_rd_ff) : '0;
   assign full    = FW'(cs_cur) + FW'(pix_ff);
   assign cs_new  = CSW'((CSW+1)'(cs_cur) - (CSW+1)'(old_row) + (CSW+1)'(pix_ff));
   assign hist_old = (32'(col_ff) >= 32'(side)) ? hist_ff[hmod_ff] : '0;
   assign ws_base = (col_ff == '0) ? '0 : ws_ff;
   assign ws_upd  = SUMW'((SUMW+1)'(ws_base) - (SUMW+1)'(hist_old) + (SUMW+1)'(full));

   assign row_ge = 32'(row_ff) >= 32'(span);
   assign col_ge = 32'(col_ff) >= 32'(span);
   assign emit   = row_ge && col_ge && (32'(h_eff) > 32'(span))
                   && (32'(w_eff) > 32'(span));
   assign last   = (32'(row_ff) == 32'(h_eff) - 1) && (32'(col_ff) == 32'(w_eff) - 1);

   assign col_next = (WW+1)'(col_ff) + (WW+1)'(1);
   assign row_next = (HB+1)'(row_ff) + (HB+1)'(1);
   assign col_wrap = col_next >= (WW+1)'(w_eff);
   assign row_wrap = row_next >= (HB+1)'(h_eff);

   always_comb begin
      row_in  = row_ff;
      col_in  = col_ff;
      rmod_in = rmod_ff;
      hmod_in = hmod_ff;
      ws_in   = ws_ff;
      if (cmd.update) begin
         ws_in = ws_upd;
         if (col_wrap) begin
            col_in  = '0;
            hmod_in = '0;
            row_in  = row_next[HB-1:0];
            if (32'(rmod_ff) + 1 >= 32'(span))
               rmod_in = '0;
            else
               rmod_in = rmod_ff + RMW'(1);
            if (row_wrap) begin
               row_in  = '0;
               rmod_in = '0;
               ws_in   = '0;
            end
         end else begin
            col_in = col_next[CW-1:0];
            if (32'(hmod_ff) + 1 >= 32'(side))
               hmod_in = '0;
            else
               hmod_in = hmod_ff + HIW'(1);
         end
      end
      if (cfg.restart) begin
         row_in  = '0;
         col_in  = '0;
         rmod_in = '0;
         hmod_in = '0;
         ws_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff  <= '0;
         col_ff  <= '0;
         rmod_ff <= '0;
         hmod_ff <= '0;
         ws_ff   <= '0;
      end else begin
         row_ff  <= row_in;
         col_ff  <= col_in;
         rmod_ff <= rmod_in;
         hmod_ff <= hmod_in;
         ws_ff   <= ws_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.update) begin
         hist_ff[hmod_ff] <= full;
         if (span != '0) begin
            cs_mem[col_ff]  <= cs_new;
            rs_mem[rs_addr] <= pix_ff;
         end
      end
   end

   // restoring divider, one quotient bit per cycle
   logic [DW-1:0]   area_ff, rem_ff, rem_in;
   logic [SUMW-1:0] quot_ff, quot_in;
   logic [CTW-1:0]  cnt_ff, cnt_in;
   logic            last_ff;
   logic [DW+1:0]   trial;

   assign trial = {1'b0, rem_ff, quot_ff[SUMW-1]} - {2'b00, area_ff};

   always_comb begin
      rem_in  = rem_ff;
      quot_in = quot_ff;
      cnt_in  = cnt_ff;
      if (cmd.div_start) begin
         // window sum of this pixel, taken before the end-of-image clear
         rem_in  = '0;
         quot_in = ws_upd;
         cnt_in  = '0;
      end else if (cmd.div_step) begin
         if (!trial[DW+1])
            rem_in = trial[DW-1:0];
         else
            rem_in = {rem_ff[DW-2:0], quot_ff[SUMW-1]};
         quot_in = {quot_ff[SUMW-2:0], !trial[DW+1]};
         cnt_in  = cnt_ff + CTW'(1);
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
      if (cmd.div_start) begin
         area_ff <= DW'(32'(side) * 32'(side));
         last_ff <= last;
      end
      if (reset)
         cnt_ff <= '0;
      else
         cnt_ff <= cnt_in;
   end

   // output register
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [bbm_pkg::FIELD_BITS-1:0] mean_ff;
   logic                           flast_ff;
   logic [SUMW+7:0]                quot_wide;

   assign quot_wide = (SUMW+8)'(quot_ff);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready)
         rsp_valid_in = 1'b0;
      if (cmd.load_out)
         rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset)
         rsp_valid_ff <= 1'b0;
      else
         rsp_valid_ff <= rsp_valid_in;
      if (cmd.load_out) begin
         mean_ff  <= quot_wide[7:0];
         flast_ff <= last_ff;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign mean_out   = mean_ff;
   assign frame_last = flast_ff;

   assign status.emit     = emit;
   assign status.div_done = (cnt_ff == CTW'(SUMW));
   assign status.out_free = !rsp_valid_ff || rsp_ready;
endmodule

/* sv/box_blur_mean_filter.sv */
// ----------------------------------------------------------------------------
// box_blur_mean_filter
// Box (mean) filter over the valid region of a raster-order pixel stream.
// ----------------------------------------------------------------------------
// Pixels arrive in raster order; for each position where the full square
// window of side 2*radius+1 fits, the truncated window mean is sent, with
// frame_last on the final one. Each pixel is captured with the line store
// read, then its sums are updated; one that yields an output then passes
// through the bit-serial divider, which forms SUMW quotient bits, where SUMW =
// PIXEL_BITS + clog2((2*MAX_RADIUS+1)^2 + 1) (15 at the defaults), and may wait
// for the output register to drain. A register write restarts the image.
module box_blur_mean_filter #(
   parameter int MAX_WIDTH  = bbm_pkg::MAX_WIDTH_DEF,
   parameter int MAX_RADIUS = bbm_pkg::MAX_RADIUS_DEF,
   parameter int PIXEL_BITS = bbm_pkg::PIXEL_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   bbm_req_if.sink                            req_ch,
   bbm_rsp_if.source                          rsp_ch,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [bbm_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [bbm_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [bbm_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                               csr_pready
);
   bbm_pkg::bbm_cfg_type    cfg;
   bbm_pkg::bbm_cmd_type    cmd;
   bbm_pkg::bbm_status_type status;

   bbm_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   bbm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   bbm_datapath #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_RADIUS (MAX_RADIUS),
      .PIXEL_BITS (PIXEL_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .cmd        (cmd),
      .status     (status),
      .pixel_in   (req_ch.pixel_in),
      .rsp_valid  (rsp_ch.valid),
      .rsp_ready  (rsp_ch.ready),
      .mean_out   (rsp_ch.mean_out),
      .frame_last (rsp_ch.frame_last)
   );
endmodule
